// ===== sv/sv32_page_table_mapper_core_defines.svh =====
// ----------------------------------------------------------------------------
// sv32_page_table_mapper_core_defines.svh
// Assertion macros shared by the page-table mapper RTL.
// ----------------------------------------------------------------------------
`ifndef SV32_PAGE_TABLE_MAPPER_CORE_DEFINES_SVH
`define SV32_PAGE_TABLE_MAPPER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SPT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SPT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sv32ptm_pkg.sv =====
// ----------------------------------------------------------------------------
// sv32ptm_pkg
// Types, widths and constants of the Sv32 page-table mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package sv32ptm_pkg;

  localparam int POOL_PAGES = 64;
  localparam int VPN_W      = 10;
  localparam int PAGE_WORDS = 1 << VPN_W;
  localparam int PPN_W      = 22;
  localparam int PAGE_IDX_W = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int FREE_W     = $clog2(POOL_PAGES + 1);
  localparam int ADDR_W     = PAGE_IDX_W + VPN_W;
  localparam int WORD_W     = 32;
  localparam int STORE_DEPTH = POOL_PAGES * PAGE_WORDS;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [5:0]  root_page;
    logic [31:0] vaddr;
    logic [31:0] phys_addr;
    logic [7:0]  flags;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  table_page;
    logic [21:0] table_ppn;
    logic        created_table;
    logic [31:0] leaf_entry;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;       // capture the input beat
    logic clr_word;    // clear one word of the next free page
    logic bump;        // take the next free page
    logic take_idx;    // adopt the page named by a valid root entry
    logic wr_root;     // write the pointer entry into the root
    logic wr_leaf;     // write the leaf entry and finish a map
    logic done_alloc;  // finish an allocate
    logic fail;        // finish with failure
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic opcode;
    logic root_ok;
    logic pool_full;
    logic root_valid;
    logic idx_ok;
    logic clr_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/sv32_page_table_mapper_core.sv =====
// ----------------------------------------------------------------------------
// sv32_page_table_mapper_core
// Sv32 two-level page-table builder over a pool of table pages.
// ----------------------------------------------------------------------------
//
//   channel   ports                       beat taken when
//   -------   -------------------------   ------------------------------
//   input     start, busy, in_item        start high and busy low
//   result    out_strobe, out_item        out_strobe high (one cycle)
//   config    cfg_we, cfg_wdata           cfg_we high
//
// A map through an existing second-level table keeps busy high through
// dispatch, root evaluation and the leaf write; the result strobe comes in
// the cycle after. An allocate, and a map that creates a table, also clear
// a page: clearing writes its 1024 words one per cycle through the single
// port of the table store.
// Failures (pool used up, root outside pool, foreign root pointer) report
// from dispatch or root evaluation and write nothing.
// Reset (rst_n low, synchronous) empties the pool pointer and clears the
// pool base; table contents are left as they are and become defined only
// once their page is allocated.
// Results cannot be stalled: each beat shows for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sv32_page_table_mapper_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // Input beat
  input  wire logic                    start,
  output logic                         busy,
  input  wire sv32ptm_pkg::in_item_t   in_item,
  // Pool base register
  input  wire logic                    cfg_we,
  input  wire logic [21:0]             cfg_wdata,
  // Result beat
  output logic                         out_strobe,
  output sv32ptm_pkg::out_item_t       out_item
);

  sv32ptm_pkg::cmd_t cmd;
  sv32ptm_pkg::sts_t sts;

  // Sequencer: decide each step from the datapath status
  sv32ptm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath: hold the beat, the store, the pointer and the result register
  sv32ptm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ===== sv/sv32ptm_ram.sv =====
// ----------------------------------------------------------------------------
// sv32ptm_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sv32ptm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/sv32ptm_ctrl.sv =====
// ----------------------------------------------------------------------------
// sv32ptm_ctrl
// Sequencer for allocate and map operations.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sv32_page_table_mapper_core_defines.svh"

module sv32ptm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire sv32ptm_pkg::sts_t  sts,
  output logic                    busy,
  output sv32ptm_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_CLR  = 3'd3;
  localparam logic [2:0] S_RWR  = 3'd4;
  localparam logic [2:0] S_LWR  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.opcode == sv32ptm_pkg::OP_ALLOC) begin
          if (sts.pool_full) begin
            cmd.fail  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_CLR;
          end
        end else if (sts.root_ok) begin
          state_nxt = S_EVAL;
        end else begin
          cmd.fail  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EVAL: begin
        if (sts.root_valid) begin
          if (sts.idx_ok) begin
            cmd.take_idx = 1'b1;
            state_nxt    = S_LWR;
          end else begin
            cmd.fail  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (sts.pool_full) begin
          cmd.fail  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cmd.clr_word = 1'b1;
        if (sts.clr_last) begin
          cmd.bump = 1'b1;
          if (sts.opcode == sv32ptm_pkg::OP_ALLOC) begin
            cmd.done_alloc = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_RWR;
          end
        end
      end
      S_RWR: begin
        cmd.wr_root = 1'b1;
        state_nxt   = S_LWR;
      end
      S_LWR: begin
        cmd.wr_leaf = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `SPT_ASSERT_IMP(a_one_finish, clk, rst_n, 1'b1, $onehot0({cmd.fail, cmd.done_alloc, cmd.wr_leaf}), "more than one finish command")
  `SPT_ASSERT_NXT(a_root_before_leaf, clk, rst_n, cmd.wr_root, state_r == S_LWR, "root write not followed by leaf write")

endmodule

`default_nettype wire

// ===== sv/sv32ptm_dp.sv =====
// ----------------------------------------------------------------------------
// sv32ptm_dp
// Datapath: table store, free-page pointer, address and entry formation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sv32_page_table_mapper_core_defines.svh"

module sv32ptm_dp (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire sv32ptm_pkg::in_item_t  in_item,
  input  wire logic                   cfg_we,
  input  wire logic [21:0]            cfg_wdata,
  input  wire sv32ptm_pkg::cmd_t      cmd,
  output sv32ptm_pkg::sts_t           sts,
  output logic                        out_strobe,
  output sv32ptm_pkg::out_item_t      out_item
);

  sv32ptm_pkg::in_item_t                  in_r;
  logic [sv32ptm_pkg::PPN_W-1:0]          base_r;
  logic [sv32ptm_pkg::FREE_W-1:0]         next_free_r;
  logic [sv32ptm_pkg::VPN_W-1:0]          clr_cnt_r;
  logic [sv32ptm_pkg::PAGE_IDX_W-1:0]     leaf_page_r;
  logic [sv32ptm_pkg::PPN_W-1:0]          leaf_ppn_r;
  logic                                   created_r;
  logic                                   out_strobe_r;
  sv32ptm_pkg::out_item_t                 out_item_r;

  logic [sv32ptm_pkg::PAGE_IDX_W-1:0]     root_idx;
  logic [sv32ptm_pkg::PAGE_IDX_W-1:0]     free_idx;
  logic [sv32ptm_pkg::VPN_W-1:0]          vpn1;
  logic [sv32ptm_pkg::VPN_W-1:0]          vpn0;
  logic [sv32ptm_pkg::PPN_W-1:0]          tppn;
  logic [sv32ptm_pkg::PPN_W-1:0]          idx_diff;
  logic [sv32ptm_pkg::PPN_W-1:0]          new_ppn;
  logic [sv32ptm_pkg::PPN_W-1:0]          alloc_ppn;
  logic [sv32ptm_pkg::WORD_W-1:0]         leaf_val;
  logic                                   ram_we;
  logic [sv32ptm_pkg::ADDR_W-1:0]         ram_addr;
  logic [sv32ptm_pkg::WORD_W-1:0]         ram_wdata;
  logic [sv32ptm_pkg::WORD_W-1:0]         ram_rdata;

  assign root_idx  = sv32ptm_pkg::PAGE_IDX_W'(in_r.root_page);
  assign free_idx  = next_free_r[sv32ptm_pkg::PAGE_IDX_W-1:0];
  assign vpn1      = in_r.vaddr[31:22];
  assign vpn0      = in_r.vaddr[21:12];
  assign tppn      = ram_rdata[31:10];
  assign idx_diff  = tppn - base_r;
  assign new_ppn   = base_r + sv32ptm_pkg::PPN_W'(leaf_page_r);
  assign alloc_ppn = base_r + sv32ptm_pkg::PPN_W'(free_idx);
  assign leaf_val  = {2'b00, in_r.phys_addr[31:12], 2'b00, in_r.flags | 8'h01};

  // Status back to the controller
  always_comb begin
    sts.opcode     = in_r.opcode;
    sts.root_ok    = 32'(in_r.root_page) < 32'(sv32ptm_pkg::POOL_PAGES);
    sts.pool_full  = next_free_r >= sv32ptm_pkg::FREE_W'(sv32ptm_pkg::POOL_PAGES);
    sts.root_valid = ram_rdata[0];
    sts.idx_ok     = idx_diff < sv32ptm_pkg::PPN_W'(sv32ptm_pkg::POOL_PAGES);
    sts.clr_last   = (clr_cnt_r == '1);
  end

  // Store port: clear sweep, root read/write and leaf write share one port
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {root_idx, vpn1};
    ram_wdata = '0;
    if (cmd.clr_word) begin
      ram_we   = 1'b1;
      ram_addr = {free_idx, clr_cnt_r};
    end else if (cmd.wr_root) begin
      ram_we    = 1'b1;
      ram_wdata = {new_ppn, 9'd0, 1'b1};
    end else if (cmd.wr_leaf) begin
      ram_we    = 1'b1;
      ram_addr  = {leaf_page_r, vpn0};
      ram_wdata = leaf_val;
    end
  end

  sv32ptm_ram #(
    .WIDTH (sv32ptm_pkg::WORD_W),
    .DEPTH (sv32ptm_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      next_free_r  <= '0;
      clr_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (cmd.bump) begin
        next_free_r <= next_free_r + 1'b1;
      end
      if (cmd.latch) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_word) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      out_strobe_r <= cmd.fail | cmd.done_alloc | cmd.wr_leaf;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_r      <= in_item;
      created_r <= 1'b0;
    end
    if (cmd.bump) begin
      leaf_page_r <= free_idx;
    end
    if (cmd.take_idx) begin
      leaf_page_r <= idx_diff[sv32ptm_pkg::PAGE_IDX_W-1:0];
      leaf_ppn_r  <= tppn;
    end
    if (cmd.wr_root) begin
      leaf_ppn_r <= new_ppn;
      created_r  <= 1'b1;
    end
    if (cmd.fail) begin
      out_item_r <= '{status: sv32ptm_pkg::ST_FAIL, table_page: '0, table_ppn: '0,
                      created_table: 1'b0, leaf_entry: '0};
    end else if (cmd.done_alloc) begin
      out_item_r.status        <= sv32ptm_pkg::ST_DONE;
      out_item_r.table_page    <= 6'(free_idx);
      out_item_r.table_ppn     <= alloc_ppn;
      out_item_r.created_table <= 1'b0;
      out_item_r.leaf_entry    <= '0;
    end else if (cmd.wr_leaf) begin
      out_item_r.status        <= sv32ptm_pkg::ST_DONE;
      out_item_r.table_page    <= 6'(leaf_page_r);
      out_item_r.table_ppn     <= leaf_ppn_r;
      out_item_r.created_table <= created_r;
      out_item_r.leaf_entry    <= leaf_val;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  `SPT_ASSERT_NXT(a_fail_holds_ptr, clk, rst_n, cmd.fail, $stable(next_free_r), "pointer moved on a failed operation")
  `SPT_ASSERT_IMP(a_ptr_bound, clk, rst_n, 1'b1, next_free_r <= sv32ptm_pkg::FREE_W'(sv32ptm_pkg::POOL_PAGES), "free pointer beyond pool")
  `SPT_ASSERT_IMP(a_clr_not_full, clk, rst_n, cmd.clr_word, !sts.pool_full, "clearing a page outside the pool")

endmodule

`default_nettype wire

// ===== verif/sv32_page_table_mapper_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sv32 page-table mapper testbench
// Drives allocate and map beats into the mapper core and checks every
// result beat against an in-bench model of the table pool, or typed rows'
// own results. A short table of directed beats comes first. Random phases
// follow, each under its own pool base and its own sender idling.
// ----------------------------------------------------------------------------

module testbench;

  localparam int ITEMS_PER_PHASE = 500;
  // Percentage of beats preceded by a sender gap, per random phase. The
  // result side cannot back-pressure, so the receiver always runs flat out.
  localparam int IDLE_PCT [4] = '{31, 0, 46, 0};

  // One row of the directed table: optional pool base write before the beat,
  // the beat itself, and the expected result where it is obvious.
  typedef struct packed {
    logic                   set_base;
    logic [21:0]            base_val;
    sv32ptm_pkg::in_item_t  job;
    logic                   typed;
    sv32ptm_pkg::out_item_t res;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [14] = '{
    // first page after reset
    '{1'b0, 22'h0, '{sv32ptm_pkg::OP_ALLOC, 6'd0, 32'h0, 32'h0, 8'h00},
      1'b1, '{sv32ptm_pkg::ST_DONE, 6'd0, 22'd0, 1'b0, 32'h0}},
    // all-zero map creates the first second-level table
    '{1'b0, 22'h0, '{sv32ptm_pkg::OP_MAP, 6'd0, 32'h0, 32'h0, 8'h00},
      1'b1, '{sv32ptm_pkg::ST_DONE, 6'd1, 22'd1, 1'b1, 32'h0000_0001}},
    // all-ones map creates a second table
    '{1'b0, 22'h0, '{sv32ptm_pkg::OP_MAP, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF},
      1'b1, '{sv32ptm_pkg::ST_DONE, 6'd2, 22'd2, 1'b1, 32'h3FFF_FCFF}},
    // through existing tables
    '{1'b0, 22'h0, '{sv32ptm_pkg::OP_MAP, 6'd0, 32'h003F_F000, 32'h1234_5678, 8'h0E},
      1'b0, '0},
    '{1'b0, 22'h0, '{sv32ptm_pkg::OP_MAP, 6'd0, 32'hFFC0_0000, 32'h8000_0FFF, 8'h01},
      1'b0, '0},
    // allocate with every ignored field at its top
    '{1'b0, 22'h0, '{sv32ptm_pkg::OP_ALLOC, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF},
      1'b1, '{sv32ptm_pkg::ST_DONE, 6'd3, 22'd3, 1'b0, 32'h0}},
    '{1'b0, 22'h0, '{sv32ptm_pkg::OP_MAP, 6'd3, 32'h0040_0000, 32'h0000_1000, 8'hCF},
      1'b0, '0},
    // a second-level table used as a root: its leaf reads as a pointer
    '{1'b0, 22'h0, '{sv32ptm_pkg::OP_MAP, 6'd1, 32'h0000_0000, 32'hABCD_E000, 8'h06},
      1'b0, '0},
    // base moved away: the old root pointer names no pool page
    '{1'b1, 22'h20_0000, '{sv32ptm_pkg::OP_MAP, 6'd0, 32'hFFFF_FFFF, 32'h0, 8'h00},
      1'b1, '{sv32ptm_pkg::ST_FAIL, 6'd0, 22'd0, 1'b0, 32'h0}},
    '{1'b0, 22'h0, '{sv32ptm_pkg::OP_ALLOC, 6'd0, 32'h0, 32'h0, 8'h00},
      1'b1, '{sv32ptm_pkg::ST_DONE, 6'd5, 22'h20_0005, 1'b0, 32'h0}},
    // page number wraps past the top of the physical space
    '{1'b1, 22'h3F_FFFE, '{sv32ptm_pkg::OP_ALLOC, 6'd0, 32'h0, 32'h0, 8'h00},
      1'b0, '0},
    '{1'b0, 22'h0, '{sv32ptm_pkg::OP_MAP, 6'd6, 32'h8000_1000, 32'hFFFF_F000, 8'h00},
      1'b0, '0},
    // base back to zero: old pointers resolve to other pool pages
    '{1'b1, 22'h0, '{sv32ptm_pkg::OP_MAP, 6'd0, 32'hFFC0_1000, 32'h0, 8'h80},
      1'b0, '0},
    '{1'b0, 22'h0, '{sv32ptm_pkg::OP_MAP, 6'd6, 32'h8000_2000, 32'h5A5A_5000, 8'h3C},
      1'b0, '0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  sv32ptm_pkg::in_item_t  in_item;
  logic                   cfg_we;
  logic [21:0]            cfg_wdata;
  logic                   out_strobe;
  sv32ptm_pkg::out_item_t out_item;

  // Pool model: table words, bump pointer and base page number
  logic [sv32ptm_pkg::WORD_W-1:0]     pool_mem [sv32ptm_pkg::STORE_DEPTH];
  logic [sv32ptm_pkg::FREE_W-1:0]     free_ptr;
  logic [sv32ptm_pkg::PPN_W-1:0]      pool_base;
  logic [sv32ptm_pkg::PAGE_IDX_W-1:0] root_pages [$];  // pages made by an allocate beat

  sv32ptm_pkg::out_item_t expected_q [$];
  sv32ptm_pkg::out_item_t want;
  int                     err_count = 0;

  sv32_page_table_mapper_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
    err_count++;
    $display("MISMATCH at %0t: %s got %h want %h", $time, what, got, exp_val);
  endtask

  // Take the next pool page and zero it; refuse once the pool is used up.
  function automatic bit claim_page(output logic [sv32ptm_pkg::PAGE_IDX_W-1:0] pg);
    pg = '0;
    if (free_ptr >= sv32ptm_pkg::POOL_PAGES) return 1'b0;
    pg = free_ptr[sv32ptm_pkg::PAGE_IDX_W-1:0];
    for (int w = 0; w < sv32ptm_pkg::PAGE_WORDS; w++)
      pool_mem[{pg, w[sv32ptm_pkg::VPN_W-1:0]}] = '0;
    free_ptr++;
    return 1'b1;
  endfunction

  // Apply one beat to the pool model and return the result it must produce.
  function automatic sv32ptm_pkg::out_item_t walk_tables(input sv32ptm_pkg::in_item_t it);
    sv32ptm_pkg::out_item_t             r;
    logic [sv32ptm_pkg::VPN_W-1:0]      vpn1;
    logic [sv32ptm_pkg::VPN_W-1:0]      vpn0;
    logic [sv32ptm_pkg::ADDR_W-1:0]     slot;
    logic [sv32ptm_pkg::PAGE_IDX_W-1:0] pg;
    logic [sv32ptm_pkg::PPN_W-1:0]      new_ppn;
    logic [sv32ptm_pkg::PPN_W-1:0]      tppn;
    logic [sv32ptm_pkg::PPN_W-1:0]      idx;
    logic [sv32ptm_pkg::WORD_W-1:0]     leaf;
    bit                                 ok;
    r = '0;
    r.status = sv32ptm_pkg::ST_FAIL;
    if (it.opcode == sv32ptm_pkg::OP_ALLOC) begin
      if (claim_page(pg)) begin
        r.status = sv32ptm_pkg::ST_DONE;
        r.table_page = pg;
        r.table_ppn = pool_base + sv32ptm_pkg::PPN_W'(pg);
      end
    end else if (int'(it.root_page) < sv32ptm_pkg::POOL_PAGES) begin
      vpn1 = it.vaddr[31:22];
      vpn0 = it.vaddr[21:12];
      slot = {it.root_page[sv32ptm_pkg::PAGE_IDX_W-1:0], vpn1};
      ok = 1'b1;
      if (pool_mem[slot][0] == 1'b0) begin
        if (claim_page(pg)) begin
          new_ppn = pool_base + sv32ptm_pkg::PPN_W'(pg);
          pool_mem[slot] = {new_ppn, 10'h001};
          r.created_table = 1'b1;
        end else begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        tppn = pool_mem[slot][31:10];
        idx = tppn - pool_base;
        if (idx < sv32ptm_pkg::POOL_PAGES) begin
          // physical page number in bits 29..10, flags below, valid forced
          leaf = {2'b00, it.phys_addr[31:12], 2'b00, it.flags | 8'h01};
          pool_mem[{idx[sv32ptm_pkg::PAGE_IDX_W-1:0], vpn0}] = leaf;
          r.status = sv32ptm_pkg::ST_DONE;
          r.table_page = idx[sv32ptm_pkg::PAGE_IDX_W-1:0];
          r.table_ppn = tppn;
          r.leaf_entry = leaf;
        end else begin
          r.created_table = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Present a beat from the falling edge and hold it until busy is low at a
  // rising edge; the beat is taken there and its expected result queued.
  task automatic send_beat(input sv32ptm_pkg::in_item_t it, input bit typed,
                           input sv32ptm_pkg::out_item_t typed_res);
    sv32ptm_pkg::out_item_t r;
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = walk_tables(it);
    expected_q.push_back(typed ? typed_res : r);
    if (it.opcode == sv32ptm_pkg::OP_ALLOC && r.status == sv32ptm_pkg::ST_DONE)
      root_pages.push_back(r.table_page);
  endtask

  // Drain the block, then write the pool base.
  task automatic write_pool_base(input logic [21:0] val);
    @(negedge clk);
    start <= 1'b0;
    while (expected_q.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    pool_base = val;
  endtask

  // Mostly well-formed maps on cleared roots, with reused upper VPNs so that
  // existing second-level tables get hit; a few allocates mixed in.
  function automatic sv32ptm_pkg::in_item_t random_job();
    sv32ptm_pkg::in_item_t it;
    it.opcode = sv32ptm_pkg::OP_MAP;
    it.root_page = 6'($urandom);
    it.vaddr = $urandom;
    it.phys_addr = $urandom;
    it.flags = 8'($urandom);
    if ($urandom_range(99) < 6) begin
      it.opcode = sv32ptm_pkg::OP_ALLOC;
    end else begin
      // only roots in pages cleared since reset
      if ($urandom_range(3) != 0)
        it.root_page = root_pages[$urandom_range(root_pages.size() - 1)];
      else
        it.root_page = 6'($urandom_range(int'(free_ptr) - 1));
      if ($urandom_range(9) < 7)
        it.vaddr[31:22] = 10'($urandom_range(3)) |
                          ($urandom_range(1) ? 10'h3FC : 10'h000);
    end
    return it;
  endfunction

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (expected_q.size() == 0) begin
        note_mismatch("result beat with nothing pending", out_item.leaf_entry, 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (out_item.status !== want.status)
          note_mismatch("status", 32'(out_item.status), 32'(want.status));
        if (out_item.table_page !== want.table_page)
          note_mismatch("table_page", 32'(out_item.table_page), 32'(want.table_page));
        if (out_item.table_ppn !== want.table_ppn)
          note_mismatch("table_ppn", 32'(out_item.table_ppn), 32'(want.table_ppn));
        if (out_item.created_table !== want.created_table)
          note_mismatch("created_table", 32'(out_item.created_table),
                        32'(want.created_table));
        if (out_item.leaf_entry !== want.leaf_entry)
          note_mismatch("leaf_entry", out_item.leaf_entry, want.leaf_entry);
      end
    end
  end

  initial begin
    dir_row_t    row;
    logic [21:0] next_base;
    int          gap;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    free_ptr = '0;
    pool_base = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: typed rows carry their own expectation
    foreach (DIR_TABLE[i]) begin
      row = DIR_TABLE[i];
      if (row.set_base) write_pool_base(row.base_val);
      send_beat(row.job, row.typed, row.res);
    end

    // Random phases. Move the base a little each time so that some old
    // pointers still land in the pool, some wrap out of it, and the top and
    // bottom of the range are both used.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: next_base = 22'h3F_FFE0;
        1: next_base = pool_base + 22'($urandom_range(1, 8));
        2: next_base = 22'h3F_FFFF;
        default: next_base = '0;
      endcase
      write_pool_base(next_base);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < IDLE_PCT[ph]) begin
          // drop start and drive junk on the item bus for a random gap
          gap = $urandom_range(1, 6);
          @(negedge clk);
          start <= 1'b0;
          in_item <= sv32ptm_pkg::in_item_t'({$urandom, $urandom, $urandom});
          repeat (gap - 1) @(negedge clk);
        end
        send_beat(random_job(), 1'b0, '0);
      end
    end

    // Drain and let the block settle
    @(negedge clk);
    start <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
